// ----- sv/cst_pkg.sv -----
// Package with the constants, codes and slot record of the counted slot table.
`default_nettype none
package cst_pkg;

  // Default table depth and the reset value of the capacity register.
  localparam int SLOT_COUNT_DEF = 32;
  localparam logic [3:0] CAP_RESET = 4'd5;

  localparam int ID_W    = 16;
  localparam int PRICE_W = 16;
  localparam int COUNT_W = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_NEW_SLOT = 3'd1,
    ST_FULL     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_SORTED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SORT   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } slot_t;

endpackage
`default_nettype wire

// ----- sv/counted_slot_table_with_price_sort.sv -----
// Top level of the counted slot table with its stable price sort.
`default_nettype none
// The table holds up to SLOT_COUNT slots (id, price, count) in one memory with a
// registered read, walked by a small sequencer around one shared compare unit. An insert reads
// the filled slots one by one, each through S_ILOOK and S_ICHECK, before its one result is
// offered. A sort selects the entries in output order: each result costs one full pass over
// the filled slots (S_SLOOK, S_SCHECK per slot), and then S_PUT hands it to the output
// register once that is free, so a sort also waits on out_tready. The block takes a new input
// transfer only when the previous item is finished; configuration writes are always taken.
module counted_slot_table_with_price_sort #(
  parameter int SLOT_COUNT = cst_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata from bit 0: item_valid, item_id[15:0], item_price[15:0], sort_ascending, zeros
  input  wire logic [cst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: command
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // out_tdata from bit 0: slot_item[15:0], slot_price[15:0], slot_count[3:0], zeros
  output logic [cst_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // out_tuser: status[2:0]
  output logic [2:0]                            out_tuser,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [3:0]                       cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ILOOK  = 6'b000010,
    S_ICHECK = 6'b000100,
    S_SLOOK  = 6'b001000,
    S_SCHECK = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]    cap_r;
  logic [CW-1:0] filled_r, filled_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [SLOT_COUNT-1:0] done_r, done_nxt;

  logic [cst_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [cst_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic                        asc_r, asc_nxt;

  cst_pkg::slot_t best_r, best_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  logic           best_valid_r, best_valid_nxt;

  cst_pkg::status_t res_status_r, res_status_nxt;
  cst_pkg::slot_t   res_slot_r, res_slot_nxt;
  logic             res_last_r, res_last_nxt;
  logic             cont_r, cont_nxt;

  logic                           out_valid_r;
  logic [cst_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [2:0]                     out_tuser_r;
  logic                           out_tlast_r;
  logic                           out_load;

  cst_pkg::slot_t mem [SLOT_COUNT];
  cst_pkg::slot_t rd_q;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  cst_pkg::slot_t mem_wd;

  logic          in_xfer;
  logic          in_item_valid;
  logic          in_cmd_sort;
  logic [CW-1:0] idx_inc;
  logic          scan_end;
  logic          id_match;
  logic          below_cap;
  logic          price_better;
  logic          cand_take;
  logic          table_has_room;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign in_xfer       = in_tvalid && in_tready;
  assign in_item_valid = in_tdata[0];
  assign in_cmd_sort   = (cst_pkg::cmd_t'(in_tuser) == cst_pkg::CMD_SORT);

  assign rd_addr        = idx_r[AW-1:0];
  assign idx_inc        = idx_r + CW'(1);
  assign scan_end       = (idx_inc == filled_r);
  assign table_has_room = (filled_r < CW'(SLOT_COUNT));

  // Shared compare unit: id equality and capacity for inserts, price order for sorts.
  assign id_match     = (rd_q.id == id_r);
  assign below_cap    = (rd_q.count < cap_r);
  assign price_better = asc_r ? (rd_q.price < best_r.price) : (rd_q.price > best_r.price);
  // Strict compare keeps the earliest slot among equal prices, which makes the order stable.
  assign cand_take    = !done_r[rd_addr] && (!best_valid_r || price_better);

  assign out_load = (state_r == S_PUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    filled_nxt     = filled_r;
    idx_nxt        = idx_r;
    emit_cnt_nxt   = emit_cnt_r;
    done_nxt       = done_r;
    id_nxt         = id_r;
    price_nxt      = price_r;
    asc_nxt        = asc_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_valid_nxt = best_valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_last_nxt   = res_last_r;
    cont_nxt       = cont_r;
    mem_we         = 1'b0;
    mem_wa         = filled_r[AW-1:0];
    mem_wd         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          id_nxt       = in_tdata[16:1];
          price_nxt    = in_tdata[32:17];
          asc_nxt      = in_tdata[33];
          idx_nxt      = '0;
          cont_nxt     = 1'b0;
          res_last_nxt = 1'b1;
          res_slot_nxt = '0;
          if (in_cmd_sort) begin
            if (filled_r == '0) begin
              res_status_nxt = cst_pkg::ST_EMPTY;
              state_nxt      = S_PUT;
            end else begin
              done_nxt       = '0;
              emit_cnt_nxt   = '0;
              best_valid_nxt = 1'b0;
              state_nxt      = S_SLOOK;
            end
          end else if (!in_item_valid) begin
            res_status_nxt = cst_pkg::ST_INVALID;
            state_nxt      = S_PUT;
          end else if (filled_r == '0) begin
            // Empty table: the first slot is opened without a scan.
            mem_we         = 1'b1;
            mem_wd.id      = in_tdata[16:1];
            mem_wd.price   = in_tdata[32:17];
            mem_wd.count   = 4'd1;
            filled_nxt     = filled_r + CW'(1);
            res_status_nxt = cst_pkg::ST_NEW_SLOT;
            res_slot_nxt   = mem_wd;
            state_nxt      = S_PUT;
          end else begin
            state_nxt = S_ILOOK;
          end
        end
      end

      S_ILOOK: begin
        state_nxt = S_ICHECK;
      end

      S_ICHECK: begin
        if (id_match && below_cap) begin
          mem_we         = 1'b1;
          mem_wa         = rd_addr;
          mem_wd         = rd_q;
          mem_wd.count   = rd_q.count + 4'd1;
          res_status_nxt = cst_pkg::ST_MERGED;
          res_slot_nxt   = mem_wd;
          state_nxt      = S_PUT;
        end else if (scan_end) begin
          if (table_has_room) begin
            mem_we         = 1'b1;
            mem_wd.id      = id_r;
            mem_wd.price   = price_r;
            mem_wd.count   = 4'd1;
            filled_nxt     = filled_r + CW'(1);
            res_status_nxt = cst_pkg::ST_NEW_SLOT;
            res_slot_nxt   = mem_wd;
          end else begin
            res_status_nxt = cst_pkg::ST_FULL;
          end
          state_nxt = S_PUT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_ILOOK;
        end
      end

      S_SLOOK: begin
        state_nxt = S_SCHECK;
      end

      S_SCHECK: begin
        if (cand_take) begin
          best_nxt       = rd_q;
          best_idx_nxt   = rd_addr;
          best_valid_nxt = 1'b1;
        end
        if (scan_end) begin
          // The pass is over: the best unsent slot is the next result.
          done_nxt[best_idx_nxt] = 1'b1;
          emit_cnt_nxt   = emit_cnt_r + CW'(1);
          res_status_nxt = cst_pkg::ST_SORTED;
          res_slot_nxt   = best_nxt;
          res_last_nxt   = (emit_cnt_nxt == filled_r);
          cont_nxt       = (emit_cnt_nxt != filled_r);
          idx_nxt        = '0;
          best_valid_nxt = 1'b0;
          state_nxt      = S_PUT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SLOOK;
        end
      end

      S_PUT: begin
        if (out_load) begin
          state_nxt = cont_r ? S_SLOOK : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= cst_pkg::CAP_RESET;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    emit_cnt_r   <= emit_cnt_nxt;
    done_r       <= done_nxt;
    id_r         <= id_nxt;
    price_r      <= price_nxt;
    asc_r        <= asc_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_valid_r <= best_valid_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_last_r   <= res_last_nxt;
    cont_r       <= cont_nxt;
    if (out_load) begin
      out_tdata_r <= {4'd0, res_slot_r.count, res_slot_r.price, res_slot_r.id};
      out_tuser_r <= res_status_r;
      out_tlast_r <= res_last_r;
    end
  end

`ifndef SYNTH
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CW'(SLOT_COUNT))
    else $error("filled slot count exceeds the table depth");

  a_filled_step: assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r != $past(filled_r)) |->
      (filled_r == $past(filled_r) + CW'(1)) &&
      ($past(state_r) == S_ICHECK || $past(state_r) == S_IDLE))
    else $error("filled slot count moved outside an insert");

  a_sort_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCHECK && scan_end) |-> (best_valid_r || cand_take))
    else $error("sort pass ended without an unsent slot");

  a_sort_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r == cst_pkg::ST_SORTED && res_last_r) |->
      (emit_cnt_r == filled_r))
    else $error("last sorted result before every slot was sent");
`endif

endmodule
`default_nettype wire
